FILE: rtl/dkbc_pkg.sv
// Shared types and constants for the debounced key blink controller.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package dkbc_pkg;

  // Debouncer phases
  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_FALLING = 2'd1,
    PH_DOWN    = 2'd2,
    PH_RISING  = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_PERIOD_ONE = 2'd1;
  localparam logic [1:0] CFG_PERIOD_TWO = 2'd2;
  localparam logic [1:0] CFG_PERIOD_THR = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 10;
  localparam int PERIOD_W   = 16;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RST   = 10'd40;
  localparam logic [PERIOD_W-1:0] PERIOD_ONE_RST = 16'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_TWO_RST = 16'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_THR_RST = 16'd1000;

  localparam logic [DEB_W-1:0] WAIT_MAX = 10'd1023;

  // Blink half-period selection
  localparam int              PERIOD_COUNT = 3;
  localparam int              PSEL_W       = 2;
  localparam logic [PSEL_W-1:0] PSEL_LAST  = PSEL_W'(PERIOD_COUNT - 1);

  // LED count limits and output field widths
  localparam int LED_COUNT_DEF = 6;
  localparam int LED_COUNT_MAX = 16;
  localparam int LSEL_MAX_W    = 4;
  localparam int LED_LINES_W   = 6;
  localparam int LED_CHOICE_W  = 3;

endpackage

`default_nettype wire

FILE: rtl/dkbc_debounce.sv
// Four-phase key debouncer: up, falling, down, rising, with a wait counter.
// Depends on dkbc_pkg.
`default_nettype none

module dkbc_debounce (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        level,
  input  wire logic [dkbc_pkg::DEB_W-1:0]  debounce_ticks,
  output logic                             released
);

  dkbc_pkg::phase_t             phase_r, phase_nxt;
  logic [dkbc_pkg::DEB_W-1:0]   wait_r, wait_nxt, wait_inc;

  // wait counter saturates at its top value
  assign wait_inc = (wait_r == dkbc_pkg::WAIT_MAX) ? wait_r : wait_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    released  = 1'b0;
    unique case (phase_r)
      dkbc_pkg::PH_UP: begin
        if (!level) begin
          phase_nxt = dkbc_pkg::PH_FALLING;
          wait_nxt  = '0;
        end
      end
      dkbc_pkg::PH_FALLING: begin
        wait_nxt = wait_inc;
        if (wait_inc >= debounce_ticks) begin
          phase_nxt = level ? dkbc_pkg::PH_UP : dkbc_pkg::PH_DOWN;
          wait_nxt  = '0;
        end
      end
      dkbc_pkg::PH_DOWN: begin
        if (level) begin
          phase_nxt = dkbc_pkg::PH_RISING;
          wait_nxt  = '0;
        end
      end
      dkbc_pkg::PH_RISING: begin
        wait_nxt = wait_inc;
        if (wait_inc >= debounce_ticks) begin
          if (level) begin
            phase_nxt = dkbc_pkg::PH_UP;
            released  = 1'b1;
          end else begin
            phase_nxt = dkbc_pkg::PH_DOWN;
          end
          wait_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dkbc_pkg::PH_UP;
      wait_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dkbc_blink.sv
// Blinker: half-period counter, LED and period selection, LED drive bits.
// Depends on dkbc_pkg.
`default_nettype none

module dkbc_blink #(
  parameter int LED_COUNT = dkbc_pkg::LED_COUNT_DEF,
  parameter int LSEL_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          rel_one,
  input  wire logic                          rel_two,
  input  wire logic [dkbc_pkg::PERIOD_W-1:0] period_one,
  input  wire logic [dkbc_pkg::PERIOD_W-1:0] period_two,
  input  wire logic [dkbc_pkg::PERIOD_W-1:0] period_thr,
  output logic      [LED_COUNT-1:0]          led_bits_nxt,
  output logic      [LSEL_W-1:0]             led_sel_nxt,
  output logic      [dkbc_pkg::PSEL_W-1:0]   period_sel_nxt
);

  logic [dkbc_pkg::PERIOD_W-1:0] count_r, count_nxt, cur_period;
  logic [dkbc_pkg::PERIOD_W:0]   count_inc;
  logic [LED_COUNT-1:0]          led_bits_r, led_mask, bits_tog;
  logic [LSEL_W-1:0]             led_sel_r;
  logic [dkbc_pkg::PSEL_W-1:0]   period_sel_r;

  always_comb begin
    case (period_sel_r)
      2'd0:    cur_period = period_one;
      2'd1:    cur_period = period_two;
      default: cur_period = period_thr;
    endcase
  end

  assign led_mask  = LED_COUNT'(1) << led_sel_r;
  assign count_inc = {1'b0, count_r} + 1'b1;
  // a period of zero behaves like one: the compare always ends the half-period
  assign count_nxt = (count_inc >= {1'b0, cur_period}) ? '0
                                                       : count_inc[dkbc_pkg::PERIOD_W-1:0];
  assign bits_tog  = (count_r == '0) ? (led_bits_r ^ led_mask) : led_bits_r;

  always_comb begin
    period_sel_nxt = period_sel_r;
    if (rel_one) begin
      period_sel_nxt = (period_sel_r == dkbc_pkg::PSEL_LAST) ? '0 : period_sel_r + 1'b1;
    end
    led_bits_nxt = bits_tog;
    led_sel_nxt  = led_sel_r;
    if (rel_two) begin
      // old LED goes dark before the selection moves on
      led_bits_nxt = bits_tog & ~led_mask;
      led_sel_nxt  = (led_sel_r == LSEL_W'(LED_COUNT - 1)) ? '0 : led_sel_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      led_bits_r   <= '0;
      led_sel_r    <= '0;
      period_sel_r <= '0;
    end else if (step) begin
      count_r      <= count_nxt;
      led_bits_r   <= led_bits_nxt;
      led_sel_r    <= led_sel_nxt;
      period_sel_r <= period_sel_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/debounced_key_blink_controller_unit.sv
// Debounced two-key LED blinker, top level.
// Channels: in_* carries one word per 1 ms tick with the raw levels of two
// active-low keys; out_* carries one result word per tick with the LED drive
// lines, the blinking LED index, the half-period index and two one-tick
// release flags. Both channels use valid/stall: a word moves on a rising
// edge with valid high and stall low.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the debounce length
// (index 0) and the three blink half-periods (1..3); write only while idle.
// Path: a tick word accepted into the input register passes through the
// update logic into the result register; a high out_stall holds it back.
// Throughput: one word per cycle while out_stall is low; the debouncers and
// blinker update in a single pass of compare/increment logic.
// Stall: the result register holds while out_stall is high; in_stall rises
// only when the input register is full and the result cannot drain.
// Reset (rst_n low, synchronous): keys idle up, LEDs off, selections zero,
// configuration back to 40/50/250/1000 ticks, both channels empty.
`default_nettype none

module debounced_key_blink_controller_unit #(
  parameter int LED_COUNT = dkbc_pkg::LED_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [dkbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dkbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_key_one_level,
  input  wire logic                             in_key_two_level,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [dkbc_pkg::LED_LINES_W-1:0]      out_led_lines,
  output logic [dkbc_pkg::LED_CHOICE_W-1:0]     out_led_choice,
  output logic [dkbc_pkg::PSEL_W-1:0]           out_period_choice,
  output logic                                  out_key_one_released,
  output logic                                  out_key_two_released
);

  localparam int LSEL_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [dkbc_pkg::DEB_W-1:0]    debounce_r;
  logic [dkbc_pkg::PERIOD_W-1:0] period_one_r, period_two_r, period_thr_r;

  logic s1_valid_r, s1_key_one_r, s1_key_two_r;
  logic advance, fire, accept;
  logic rel_one, rel_two;

  logic [LED_COUNT-1:0]                 led_bits_nxt;
  logic [LSEL_W-1:0]                    led_sel_nxt;
  logic [dkbc_pkg::PSEL_W-1:0]          period_sel_nxt;
  logic [dkbc_pkg::LED_COUNT_MAX-1:0]   led_bits_wide;
  logic [dkbc_pkg::LSEL_MAX_W-1:0]      led_sel_wide;

  logic                                 out_valid_r;
  logic [dkbc_pkg::LED_LINES_W-1:0]     out_led_lines_r;
  logic [dkbc_pkg::LED_CHOICE_W-1:0]    out_led_choice_r;
  logic [dkbc_pkg::PSEL_W-1:0]          out_period_choice_r;
  logic                                 out_rel_one_r, out_rel_two_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= dkbc_pkg::DEBOUNCE_RST;
      period_one_r <= dkbc_pkg::PERIOD_ONE_RST;
      period_two_r <= dkbc_pkg::PERIOD_TWO_RST;
      period_thr_r <= dkbc_pkg::PERIOD_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dkbc_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[dkbc_pkg::DEB_W-1:0];
        dkbc_pkg::CFG_PERIOD_ONE: period_one_r <= cfg_wdata;
        dkbc_pkg::CFG_PERIOD_TWO: period_two_r <= cfg_wdata;
        dkbc_pkg::CFG_PERIOD_THR: period_thr_r <= cfg_wdata;
      endcase
    end
  end

  // handshake: input register feeds the result register
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_one_r <= in_key_one_level;
      s1_key_two_r <= in_key_two_level;
    end
  end

  dkbc_debounce u_deb_one (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (fire),
    .level          (s1_key_one_r),
    .debounce_ticks (debounce_r),
    .released       (rel_one)
  );

  dkbc_debounce u_deb_two (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (fire),
    .level          (s1_key_two_r),
    .debounce_ticks (debounce_r),
    .released       (rel_two)
  );

  dkbc_blink #(
    .LED_COUNT (LED_COUNT),
    .LSEL_W    (LSEL_W)
  ) u_blink (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (fire),
    .rel_one        (rel_one),
    .rel_two        (rel_two),
    .period_one     (period_one_r),
    .period_two     (period_two_r),
    .period_thr     (period_thr_r),
    .led_bits_nxt   (led_bits_nxt),
    .led_sel_nxt    (led_sel_nxt),
    .period_sel_nxt (period_sel_nxt)
  );

  // outputs show only the low bits of a wider LED set
  assign led_bits_wide = dkbc_pkg::LED_COUNT_MAX'(led_bits_nxt);
  assign led_sel_wide  = dkbc_pkg::LSEL_MAX_W'(led_sel_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_led_lines_r     <= led_bits_wide[dkbc_pkg::LED_LINES_W-1:0];
      out_led_choice_r    <= led_sel_wide[dkbc_pkg::LED_CHOICE_W-1:0];
      out_period_choice_r <= period_sel_nxt;
      out_rel_one_r       <= rel_one;
      out_rel_two_r       <= rel_two;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_led_lines        = out_led_lines_r;
  assign out_led_choice       = out_led_choice_r;
  assign out_period_choice    = out_period_choice_r;
  assign out_key_one_released = out_rel_one_r;
  assign out_key_two_released = out_rel_two_r;

endmodule

`default_nettype wire

FILE: rtl/dkbc_checker.sv
// Port-level checks for the debounced key blink controller.
// Depends on dkbc_pkg; bound to debounced_key_blink_controller_unit.
`default_nettype none

module dkbc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [dkbc_pkg::LED_LINES_W-1:0] out_led_lines,
  input wire logic [dkbc_pkg::LED_CHOICE_W-1:0] out_led_choice,
  input wire logic [dkbc_pkg::PSEL_W-1:0]      out_period_choice,
  input wire logic                             out_key_one_released,
  input wire logic                             out_key_two_released
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_lines)
      && $stable(out_led_choice) && $stable(out_period_choice)
      && $stable(out_key_one_released) && $stable(out_key_two_released))
    else $error("result word changed while stalled");

  // at most one LED is ever lit
  a_one_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_led_lines))
    else $error("more than one LED lit");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_period_choice <= dkbc_pkg::PSEL_LAST)
    else $error("half-period index out of range");

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // with the pipeline empty after reset, input must be taken
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind debounced_key_blink_controller_unit dkbc_checker u_dkbc_checker (.*);

`default_nettype wire
